[design/bafr_pkg.sv]
// Shared types, constants and the reciprocal table of the box average filter.
package bafr_pkg;

    localparam int ROW_W     = 12;  // row counters and image height
    localparam int CFG_W_W   = 11;  // image_width register
    localparam int WIN_W     = 3;   // window_size register
    localparam int CH_W      = 2;   // channel_count register
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int K_W       = 2;   // half window, window_size >> 1
    localparam int TAP_W     = 3;   // tap counter, 0 .. 2*half
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 14;  // 49 * 255 fits
    localparam int RECIP_W   = 21;
    localparam int RECIP_SH  = 20;
    localparam int PROD_W    = SUM_W + RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_WINDOW   = 2'd2,
        CFG_CHANNELS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic clear;   // start a new window sum
        logic acc_en;  // add the registered tap
        logic mul_en;  // register sum times reciprocal
    } t_lane_ctl;

    // ceil(2^20 / side^2); exact floor division for every window sum
    function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
        logic [RECIP_W-1:0] m;
        unique case (k)
            2'd0: m = 21'd1048576;
            2'd1: m = 21'd116509;
            2'd2: m = 21'd41944;
            2'd3: m = 21'd21400;
            default: m = 21'd1048576;
        endcase
        return m;
    endfunction

endpackage

[design/bafr_if.sv]
// Stream and configuration channel interfaces of the box average filter.
interface bafr_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    modport source (output valid, mode, chan_a, chan_b, chan_c, input ready);
    modport sink   (input valid, mode, chan_a, chan_b, chan_c, output ready);
endinterface

interface bafr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] avg_a;
    logic [7:0] avg_b;
    logic [7:0] avg_c;
    logic       frame_last;
    modport source (output valid, avg_a, avg_b, avg_c, frame_last, input ready);
    modport sink   (input valid, avg_a, avg_b, avg_c, frame_last, output ready);
endinterface

interface bafr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/bafr_line_store.sv]
// Ring of line buffers: one write port, one registered read port.
module bafr_line_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/bafr_lane.sv]
// One channel lane: window accumulator and reciprocal multiply.
module bafr_lane (
    input  logic                  i_clk,
    input  bafr_pkg::t_lane_ctl   i_ctl,
    input  logic [7:0]            i_pix,
    input  logic [1:0]            i_half,
    input  logic                  i_active,
    output logic [7:0]            o_avg
);
    import bafr_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.acc_en) begin
            r_sum <= r_sum + SUM_W'(i_pix);
        end
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(recip(i_half));
        end
    end

    assign o_avg = i_active ? r_prod[RECIP_SH +: PIX_W] : '0;
endmodule

[design/box_average_filter_reflect.sv]
// Top level of the box average filter with mirrored borders.
//
//  channel  dir  fields                               transfer when
//  i_pix    in   mode, chan_a, chan_b, chan_c         valid && ready
//  o_res    out  avg_a, avg_b, avg_c, frame_last      valid && ready
//  i_cfg    in   index, data                          valid && ready (ready always 1)
//
// An item that frees no output ends with its transfer; otherwise the single read port of
// the line store is swept once per window tap, followed by the S_LAST, S_MUL (multiply)
// and S_LOAD (output load) states.
// Reset (i_rst_n low, synchronous) restores the register defaults and clears
// all position counters; the line store needs no clearing.
// The result waits in an output register; a stalled output holds the block in
// its load state while the next item is refused.
module box_average_filter_reflect #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7,
    parameter int LANES      = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bafr_pix_if.sink     i_pix,
    bafr_res_if.source   o_res,
    bafr_cfg_if.sink     i_cfg
);
    import bafr_pkg::*;

    localparam int RING   = (MAX_WINDOW / 2) * 2 + 2;
    localparam int RING_W = $clog2(RING);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = ($clog2(MAX_WIDTH + 1) > CFG_W_W) ? $clog2(MAX_WIDTH + 1)
                                                                : CFG_W_W;
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAXK   = MAX_WINDOW / 2;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_MUL, S_LOAD} t_state;

    // configuration registers
    logic [CFG_W_W-1:0] r_width;
    logic [ROW_W-1:0]   r_height;
    logic [WIN_W-1:0]   r_window;
    logic [CH_W-1:0]    r_chans;

    // position counters
    logic [CW-1:0]      r_in_col, r_out_col;
    logic [ROW_W-1:0]   r_in_row, r_out_row;
    logic [RING_W-1:0]  r_in_ring, r_out_ring;

    t_state             r_state;
    logic [TAP_W-1:0]   r_ty, r_tx;
    logic               r_rd_vld;

    logic               r_ovalid;
    logic [7:0]         r_avg [3];
    logic               r_last;

    // effective geometry
    logic [WW-1:0]      w_eff, w_m1;
    logic [ROW_W-1:0]   h_eff, h_m1;
    logic [K_W-1:0]     k_eff;
    logic [CH_W-1:0]    lanes_eff;
    logic [TAP_W-1:0]   k2;

    always_comb begin
        logic [K_W-1:0] k;
        w_eff = (r_width == '0) ? WW'(1)
              : ((WW'(r_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_width));
        w_m1  = w_eff - WW'(1);
        h_eff = (r_height == '0) ? ROW_W'(1) : r_height;
        h_m1  = h_eff - ROW_W'(1);
        k = r_window[WIN_W-1:1];
        if (32'(k) > MAXK) k = K_W'(MAXK);
        if (WW'(k) > w_m1) k = K_W'(w_m1);
        if (ROW_W'(k) > h_m1) k = K_W'(h_m1);
        k_eff = k;
        k2 = TAP_W'({k, 1'b0});
        lanes_eff = (r_chans == '0) ? CH_W'(1) : r_chans;
        if (32'(lanes_eff) > LANES) lanes_eff = CH_W'(LANES);
    end

    // input side: pixel write and next input position
    logic               pix_xfer, pix_wr, out_ready;
    logic [CW-1:0]      n_in_col;
    logic [ROW_W-1:0]   n_in_row;
    logic [RING_W-1:0]  n_in_ring;

    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_xfer    = i_pix.valid && i_pix.ready;
    assign pix_wr      = pix_xfer && !i_pix.mode && (r_in_row < h_eff);

    always_comb begin
        logic [ROW_W:0] need_row;
        logic [WW:0]    need_col;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_ring = r_in_ring;
        if (pix_wr) begin
            if ((WW'(r_in_col) + WW'(1)) >= w_eff) begin
                n_in_col  = '0;
                n_in_row  = r_in_row + ROW_W'(1);
                n_in_ring = (32'(r_in_ring) == RING - 1) ? '0 : r_in_ring + RING_W'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        need_row = (ROW_W + 1)'(r_out_row) + (ROW_W + 1)'(k_eff);
        if (need_row > (ROW_W + 1)'(h_m1)) need_row = (ROW_W + 1)'(h_m1);
        need_col = (WW + 1)'(r_out_col) + (WW + 1)'(k_eff);
        if (need_col > (WW + 1)'(w_m1)) need_col = (WW + 1)'(w_m1);
        out_ready = (n_in_row >= h_eff) || ((ROW_W + 1)'(n_in_row) > need_row)
                 || (((ROW_W + 1)'(n_in_row) == need_row)
                     && ((WW + 1)'(n_in_col) > need_col));
    end

    // tap address: mirrored row mapped into the ring, mirrored column
    logic [AW-1:0] waddr, raddr;

    always_comb begin
        logic signed [TAP_W:0]   dy, dx;
        logic signed [ROW_W+1:0] ra, roff;
        logic signed [WW+1:0]    ca;
        logic signed [RING_W+1:0] rs;
        dy = $signed({1'b0, r_ty}) - $signed((TAP_W + 1)'(k_eff));
        dx = $signed({1'b0, r_tx}) - $signed((TAP_W + 1)'(k_eff));
        ra = $signed((ROW_W + 2)'(r_out_row)) + (ROW_W + 2)'(dy);
        if (ra < 0) begin
            ra = -ra;
        end else if (ra > $signed((ROW_W + 2)'(h_m1))) begin
            ra = $signed((ROW_W + 2)'({h_m1, 1'b0})) - ra;
        end
        roff = ra - $signed((ROW_W + 2)'(r_out_row));
        rs = $signed((RING_W + 2)'(r_out_ring)) + (RING_W + 2)'(roff);
        if (rs < 0) begin
            rs = rs + (RING_W + 2)'(RING);
        end else if (rs >= $signed((RING_W + 2)'(RING))) begin
            rs = rs - (RING_W + 2)'(RING);
        end
        ca = $signed((WW + 2)'(r_out_col)) + (WW + 2)'(dx);
        if (ca < 0) begin
            ca = -ca;
        end else if (ca > $signed((WW + 2)'(w_m1))) begin
            ca = $signed((WW + 2)'({w_m1, 1'b0})) - ca;
        end
        raddr = AW'(AW'(rs[RING_W-1:0]) * AW'(MAX_WIDTH) + AW'(ca[CW-1:0]));
        waddr = AW'(AW'(r_in_ring) * AW'(MAX_WIDTH) + AW'(r_in_col));
    end

    logic [23:0] rdata;

    bafr_line_store #(.DEPTH(DEPTH), .AW(AW), .DW(24)) u_store (
        .i_clk   (i_clk),
        .i_we    (pix_wr),
        .i_waddr (waddr),
        .i_wdata ({i_pix.chan_c, i_pix.chan_b, i_pix.chan_a}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // lanes
    t_lane_ctl  lane_ctl;
    logic [7:0] lane_avg [3];

    assign lane_ctl.clear  = pix_xfer && out_ready;
    assign lane_ctl.acc_en = r_rd_vld;
    assign lane_ctl.mul_en = (r_state == S_MUL);

    for (genvar l = 0; l < 3; l++) begin : g_lane
        if (l < LANES) begin : g_on
            bafr_lane u_lane (
                .i_clk    (i_clk),
                .i_ctl    (lane_ctl),
                .i_pix    (rdata[8*l +: 8]),
                .i_half   (k_eff),
                .i_active (CH_W'(l) < lanes_eff),
                .o_avg    (lane_avg[l])
            );
        end else begin : g_off
            assign lane_avg[l] = '0;
        end
    end

    // merge stage and output register
    logic load, is_last, cfg_xfer;

    assign load     = (r_state == S_LOAD) && (!r_ovalid || o_res.ready);
    assign is_last  = (r_out_row == h_m1) && (WW'(r_out_col) == w_m1);
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CFG_W_W'(640);
            r_height   <= ROW_W'(480);
            r_window   <= WIN_W'(3);
            r_chans    <= CH_W'(1);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_ring  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_ring <= '0;
            r_state    <= S_IDLE;
            r_ty       <= '0;
            r_tx       <= '0;
            r_rd_vld   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
            // a load in the same cycle refills the register instead
            if (o_res.valid && o_res.ready && !(load && !cfg_xfer)) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_xfer) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_WIDTH:    r_width  <= i_cfg.data[CFG_W_W-1:0];
                    CFG_HEIGHT:   r_height <= i_cfg.data[ROW_W-1:0];
                    CFG_WINDOW:   r_window <= i_cfg.data[WIN_W-1:0];
                    CFG_CHANNELS: r_chans  <= i_cfg.data[CH_W-1:0];
                    default: ;
                endcase
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_ring  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_ring <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (pix_xfer) begin
                            r_in_col  <= n_in_col;
                            r_in_row  <= n_in_row;
                            r_in_ring <= n_in_ring;
                            if (out_ready) begin
                                r_ty    <= '0;
                                r_tx    <= '0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                    S_SCAN: begin
                        if (r_tx == k2) begin
                            r_tx <= '0;
                            if (r_ty == k2) begin
                                r_state <= S_LAST;
                            end else begin
                                r_ty <= r_ty + TAP_W'(1);
                            end
                        end else begin
                            r_tx <= r_tx + TAP_W'(1);
                        end
                    end
                    S_LAST: r_state <= S_MUL;
                    S_MUL:  r_state <= S_LOAD;
                    S_LOAD: begin
                        if (load) begin
                            r_ovalid <= 1'b1;
                            r_avg[0] <= lane_avg[0];
                            r_avg[1] <= lane_avg[1];
                            r_avg[2] <= lane_avg[2];
                            r_last   <= is_last;
                            r_state  <= S_IDLE;
                            if (is_last) begin
                                r_in_col   <= '0;
                                r_in_row   <= '0;
                                r_in_ring  <= '0;
                                r_out_col  <= '0;
                                r_out_row  <= '0;
                                r_out_ring <= '0;
                            end else if (WW'(r_out_col) == w_m1) begin
                                r_out_col  <= '0;
                                r_out_row  <= r_out_row + ROW_W'(1);
                                r_out_ring <= (32'(r_out_ring) == RING - 1) ? '0
                                            : r_out_ring + RING_W'(1);
                            end else begin
                                r_out_col <= r_out_col + CW'(1);
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.avg_a      = r_avg[0];
    assign o_res.avg_b      = r_avg[1];
    assign o_res.avg_c      = r_avg[2];
    assign o_res.frame_last = r_last;

    // taps stay inside the window
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ty <= k2 && r_tx <= k2))
        else $error("tap counter beyond window");

    // a read is only in flight right after a scan cycle
    a_no_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_MUL) |-> !r_rd_vld)
        else $error("accumulate outside window sweep");

    // the last output of a frame rewinds all positions
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && is_last && !cfg_xfer) |=> (r_out_row == '0 && r_in_row == '0
                                           && r_out_col == '0 && r_in_col == '0))
        else $error("frame end did not restart counters");
endmodule
